// ===== hw/rtl/blit_rectangle_clipper_unit_macros.svh =====
// assertion macros shared by the rectangle clipper rtl
// included by modules that carry concurrent checks
`ifndef BLIT_RECTANGLE_CLIPPER_UNIT_MACROS_SVH
`define BLIT_RECTANGLE_CLIPPER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/brc_pkg.sv =====
// types and constants for the blitter rectangle clipper
// no dependencies; used by every other rtl file of the block except the macro header
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W    = 20;

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_IMAGE = 2'd1,
    MODE_COPY  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_CLIENT_X = 3'd2,
    CFG_CLIENT_Y = 3'd3,
    CFG_CLIENT_W = 3'd4,
    CFG_CLIENT_H = 3'd5,
    CFG_PAN_X    = 3'd6,
    CFG_PAN_Y    = 3'd7
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [CFG_DATA_W-1:0] SCREEN_H_RST = 13'd480;
  localparam logic [CFG_DATA_W-1:0] CLIENT_W_RST = 13'd640;
  localparam logic [CFG_DATA_W-1:0] CLIENT_H_RST = 13'd480;

  typedef logic signed [COORD_W-1:0] coord_t;
  localparam coord_t COORD_ZERO = '0;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] screen_width;
    logic [CFG_DATA_W-1:0] screen_height;
    logic [CFG_DATA_W-1:0] client_x_offset;
    logic [CFG_DATA_W-1:0] client_y_offset;
    logic [CFG_DATA_W-1:0] client_width;
    logic [CFG_DATA_W-1:0] client_height;
    logic [CFG_DATA_W-1:0] pan_x;
    logic [CFG_DATA_W-1:0] pan_y;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               from_client;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
  } cmd_t;

  typedef struct packed {
    logic        draw;
    logic [13:0] out_x;
    logic [13:0] out_y;
    logic [12:0] out_w;
    logic [12:0] out_h;
    logic [13:0] out_dest_x;
    logic [13:0] out_dest_y;
    logic [15:0] skip_left;
    logic [15:0] skip_top;
    logic [15:0] skip_right;
  } res_t;

  // per-axis control from the command decode
  typedef struct packed {
    logic use_offset;
    logic fill;
    logic copy;
  } axis_ctl_t;

  // per-axis clip outcome
  typedef struct packed {
    logic        ok;
    logic        nonzero;
    logic [13:0] pos;
    logic [12:0] size;
    logic [13:0] dest;
    logic [15:0] skip_lo;
    logic [15:0] skip_hi;
  } axis_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brc_cmd_if.sv =====
// valid/ready channel interfaces for commands and clip results
// depends on brc_pkg for the payload structs
`timescale 1ns / 1ps
`default_nettype none

interface brc_cmd_if;
  logic           valid;
  logic           ready;
  brc_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brc_res_if;
  logic           valid;
  logic           ready;
  brc_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/brc_cfg_regs.sv =====
// configuration register file of the rectangle clipper
// depends on brc_pkg for register indexes and reset values
`timescale 1ns / 1ps
`default_nettype none

module brc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [brc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output brc_pkg::cfg_t                       cfg
);
  import brc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_W: cfg_nxt.screen_width    = cfg_data;
        CFG_SCREEN_H: cfg_nxt.screen_height   = cfg_data;
        CFG_CLIENT_X: cfg_nxt.client_x_offset = cfg_data;
        CFG_CLIENT_Y: cfg_nxt.client_y_offset = cfg_data;
        CFG_CLIENT_W: cfg_nxt.client_width    = cfg_data;
        CFG_CLIENT_H: cfg_nxt.client_height   = cfg_data;
        CFG_PAN_X:    cfg_nxt.pan_x           = cfg_data;
        CFG_PAN_Y:    cfg_nxt.pan_y           = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= SCREEN_W_RST;
      cfg_r.screen_height   <= SCREEN_H_RST;
      cfg_r.client_x_offset <= '0;
      cfg_r.client_y_offset <= '0;
      cfg_r.client_width    <= CLIENT_W_RST;
      cfg_r.client_height   <= CLIENT_H_RST;
      cfg_r.pan_x           <= '0;
      cfg_r.pan_y           <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/brc_axis_clip.sv =====
// one-axis clipper: offset, near/far edge clip, copy destination clip, pan
// depends on brc_pkg for coordinate and control types
`timescale 1ns / 1ps
`default_nettype none

module brc_axis_clip (
  input  logic signed [15:0]                  pos,
  input  logic [15:0]                         size,
  input  logic signed [15:0]                  dest,
  input  logic [brc_pkg::CFG_DATA_W-1:0]      offset,
  input  logic [brc_pkg::CFG_DATA_W-1:0]      limit,
  input  logic [brc_pkg::CFG_DATA_W-1:0]      pan,
  input  brc_pkg::axis_ctl_t                  ctl,
  output brc_pkg::axis_res_t                  res
);
  import brc_pkg::*;

  coord_t off_ext, lim, pan_ext;
  coord_t p0, np, sz0, p1, sz1, lo, d1, end1, sz2, hi;
  coord_t nd, sz3, p2, d2, dend, sz4;
  coord_t pf, szf, df, pf_pan, df_pan;
  logic   neg, rej_far, rej_near, over;
  logic   dneg, rej_dfar, rej_dnear, dover;

  assign off_ext = ctl.use_offset ? coord_t'(offset) : COORD_ZERO;
  assign lim     = coord_t'(limit);
  assign pan_ext = coord_t'(pan);

  // source clip against 0..limit
  assign p0       = coord_t'(pos) + off_ext;
  assign sz0      = coord_t'(size);
  assign np       = -p0;
  assign neg      = p0 < COORD_ZERO;
  assign rej_far  = p0 > lim;
  assign rej_near = neg && (ctl.fill ? (np >= sz0) : (np > sz0));

  assign p1   = neg ? COORD_ZERO : p0;
  assign sz1  = neg ? (sz0 + p0) : sz0;
  assign lo   = neg ? np : COORD_ZERO;
  // destination follows the cut at the near edge
  assign d1   = coord_t'(dest) + lo;

  assign end1 = p1 + sz1;
  assign over = end1 > lim;
  assign sz2  = over ? (lim - p1) : sz1;
  assign hi   = over ? (end1 - lim) : COORD_ZERO;

  // destination clip, moving the source along
  assign rej_dfar  = d1 > lim;
  assign dneg      = d1 < COORD_ZERO;
  assign nd        = -d1;
  assign rej_dnear = dneg && (nd > sz2);
  assign sz3       = dneg ? (sz2 + d1) : sz2;
  assign p2        = dneg ? (p1 + nd) : p1;
  assign d2        = dneg ? COORD_ZERO : d1;
  assign dend      = d2 + sz3;
  assign dover     = dend > lim;
  assign sz4       = dover ? (lim - d2) : sz3;

  assign pf  = ctl.copy ? p2 : p1;
  assign szf = ctl.copy ? sz4 : sz2;
  assign df  = ctl.copy ? d2 : COORD_ZERO;

  assign pf_pan = pf + pan_ext;
  assign df_pan = df + pan_ext;

  always_comb begin
    res.ok      = !rej_far && !rej_near && !(ctl.copy && (rej_dfar || rej_dnear));
    res.nonzero = szf > COORD_ZERO;
    res.pos     = pf_pan[13:0];
    res.size    = szf[12:0];
    res.dest    = df_pan[13:0];
    res.skip_lo = lo[15:0];
    res.skip_hi = hi[15:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/blit_rectangle_clipper_unit.sv =====
// Rectangle clipping front end of a 2D blitter. Accepts one command per
// clock cycle while the result channel is not stalled and returns exactly
// one result per command. A command is captured in an input register,
// clipped per axis by purely combinational logic, and the result is held
// in an output register; the input register can take one more command
// while a finished result waits to be taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// and must only change while no command is in flight.
// Depends on brc_pkg, brc_cmd_if, brc_cfg_regs, brc_axis_clip and the
// macro header blit_rectangle_clipper_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "blit_rectangle_clipper_unit_macros.svh"

module blit_rectangle_clipper_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  brc_cmd_if.sink                             in_cmd,
  brc_res_if.source                           out_res,
  input  logic                                cfg_we,
  input  logic [brc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import brc_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  cmd_t      s1_cmd_r;
  logic      out_valid_r, out_valid_nxt;
  res_t      out_data_r, res_nxt;
  logic      out_adv, in_ready, in_xfer, s1_adv;
  axis_ctl_t ctl;
  axis_res_t xr, yr;
  logic      mode_ok, is_copy, is_image;
  logic [CFG_DATA_W-1:0] lim_x, lim_y;

  brc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: result register frees when taken, input register when it moves on
  assign out_adv  = !out_valid_r || out_res.ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_xfer  = in_cmd.valid && in_ready;
  assign s1_adv   = s1_valid_r && out_adv;

  assign in_cmd.ready  = in_ready;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_cmd.valid;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_cmd.data;
    end
    if (s1_adv) begin
      out_data_r <= res_nxt;
    end
  end

  // command decode
  assign mode_ok  = s1_cmd_r.mode != MODE_RSVD;
  assign is_copy  = s1_cmd_r.mode == MODE_COPY;
  assign is_image = s1_cmd_r.mode == MODE_IMAGE;
  assign lim_x    = s1_cmd_r.from_client ? cfg.client_width  : cfg.screen_width;
  assign lim_y    = s1_cmd_r.from_client ? cfg.client_height : cfg.screen_height;

  always_comb begin
    ctl.use_offset = s1_cmd_r.from_client;
    ctl.fill       = s1_cmd_r.mode == MODE_FILL;
    ctl.copy       = is_copy;
  end

  brc_axis_clip u_clip_x (
    .pos    (s1_cmd_r.rect_x),
    .size   (s1_cmd_r.rect_w),
    .dest   (s1_cmd_r.dest_x),
    .offset (cfg.client_x_offset),
    .limit  (lim_x),
    .pan    (cfg.pan_x),
    .ctl    (ctl),
    .res    (xr)
  );

  brc_axis_clip u_clip_y (
    .pos    (s1_cmd_r.rect_y),
    .size   (s1_cmd_r.rect_h),
    .dest   (s1_cmd_r.dest_y),
    .offset (cfg.client_y_offset),
    .limit  (lim_y),
    .pan    (cfg.pan_y),
    .ctl    (ctl),
    .res    (yr)
  );

  // a rejected or empty command gives an all-zero result
  always_comb begin
    res_nxt = '0;
    if (mode_ok && xr.ok && yr.ok && xr.nonzero && yr.nonzero) begin
      res_nxt.draw  = 1'b1;
      res_nxt.out_x = xr.pos;
      res_nxt.out_y = yr.pos;
      res_nxt.out_w = xr.size;
      res_nxt.out_h = yr.size;
      if (is_copy) begin
        res_nxt.out_dest_x = xr.dest;
        res_nxt.out_dest_y = yr.dest;
      end
      if (is_image) begin
        res_nxt.skip_left  = xr.skip_lo;
        res_nxt.skip_top   = yr.skip_lo;
        res_nxt.skip_right = xr.skip_hi;
      end
    end
  end

  `BRC_ASSERT_NOW(a_nodraw_zero, clk, rst_n, out_valid_r && !out_data_r.draw, out_data_r == '0, "result without draw carries nonzero fields")
  `BRC_ASSERT_NOW(a_draw_nonempty, clk, rst_n, out_valid_r && out_data_r.draw, (out_data_r.out_w != '0) && (out_data_r.out_h != '0), "drawn result has empty size")
  `BRC_ASSERT_NOW(a_skip_no_dest, clk, rst_n, out_valid_r && ((out_data_r.skip_left != '0) || (out_data_r.skip_top != '0) || (out_data_r.skip_right != '0)), (out_data_r.out_dest_x == '0) && (out_data_r.out_dest_y == '0), "skip counts and copy destination both set")
  `BRC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !out_adv, s1_valid_r && $stable(s1_cmd_r), "held command lost while result stalled")
  `BRC_ASSERT_NEXT(a_xfer_loads, clk, rst_n, in_xfer, s1_valid_r, "accepted command not captured")

endmodule

`default_nettype wire
